// File: sv/ktr_pkg.sv
// ----------------------------------------------------------------------------
// ktr_pkg
// Shared types, constants and the scan-code character ROM of the typematic
// repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package ktr_pkg;

  localparam int unsigned NumKeys        = 256;
  localparam int unsigned KeyW           = 8;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned CfgW           = 16;
  localparam int unsigned CharW          = 8;

  localparam logic [CfgW-1:0] DelayRst    = 16'd400;
  localparam logic [CfgW-1:0] IntervalRst = 16'd75;

  // register indexes
  localparam logic RegInitialDelay  = 1'b0;
  localparam logic RegRepeatInterval = 1'b1;

  // control characters
  localparam logic [CharW-1:0] ChEsc  = 8'd27;
  localparam logic [CharW-1:0] ChBs   = 8'h08;
  localparam logic [CharW-1:0] ChTab  = 8'h09;
  localparam logic [CharW-1:0] ChCr   = 8'h0D;
  localparam logic [CharW-1:0] ChNone = 8'h00;

  typedef struct packed {
    logic             held;
    logic             rpt;
    logic [TimeW-1:0] stamp;
  } entry_t;

  function automatic logic [CharW-1:0] scan_char(input logic [KeyW-1:0] code);
    logic [CharW-1:0] ch;
    case (code)
      8'd1:    ch = ChEsc;
      8'd2:    ch = "1";
      8'd3:    ch = "2";
      8'd4:    ch = "3";
      8'd5:    ch = "4";
      8'd6:    ch = "5";
      8'd7:    ch = "6";
      8'd8:    ch = "7";
      8'd9:    ch = "8";
      8'd10:   ch = "9";
      8'd11:   ch = "0";
      8'd12:   ch = "-";
      8'd13:   ch = "=";
      8'd14:   ch = ChBs;
      8'd15:   ch = ChTab;
      8'd16:   ch = "Q";
      8'd17:   ch = "W";
      8'd18:   ch = "E";
      8'd19:   ch = "R";
      8'd20:   ch = "T";
      8'd21:   ch = "Y";
      8'd22:   ch = "U";
      8'd23:   ch = "I";
      8'd24:   ch = "O";
      8'd25:   ch = "P";
      8'd26:   ch = "[";
      8'd27:   ch = "]";
      8'd28:   ch = ChCr;
      8'd30:   ch = "A";
      8'd31:   ch = "S";
      8'd32:   ch = "D";
      8'd33:   ch = "F";
      8'd34:   ch = "G";
      8'd35:   ch = "H";
      8'd36:   ch = "J";
      8'd37:   ch = "K";
      8'd38:   ch = "L";
      8'd39:   ch = ";";
      8'd40:   ch = 8'h27;
      8'd43:   ch = 8'h5C;
      8'd44:   ch = "Z";
      8'd45:   ch = "X";
      8'd46:   ch = "C";
      8'd47:   ch = "V";
      8'd48:   ch = "B";
      8'd49:   ch = "N";
      8'd50:   ch = "M";
      8'd51:   ch = ",";
      8'd52:   ch = ".";
      8'd53:   ch = "/";
      8'd55:   ch = "*";
      8'd57:   ch = " ";
      default: ch = ChNone;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: sv/ktr_ram.sv
// ----------------------------------------------------------------------------
// ktr_ram
// Per-key state memory with registered read, per-entry valid bits
// for reset clearing and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module ktr_ram #(
  parameter int unsigned NUM_KEYS = ktr_pkg::NumKeys,
  parameter int unsigned AW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire ktr_pkg::entry_t wr_data_i,
  output ktr_pkg::entry_t      rd_data_o
);

  ktr_pkg::entry_t       mem [NUM_KEYS];
  ktr_pkg::entry_t       rdata_q;
  ktr_pkg::entry_t       fwd_q;
  logic [NUM_KEYS-1:0]   vld_q;
  logic                  rd_vld_q;
  logic                  fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      fwd_q   <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_comb begin
    if (fwd_hit_q) begin
      rd_data_o = fwd_q;
    end else if (rd_vld_q) begin
      rd_data_o = rdata_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

// File: sv/ktr_update.sv
// ----------------------------------------------------------------------------
// ktr_update
// Typematic rule: computes a key's next state and whether it emits.
// ----------------------------------------------------------------------------
`default_nettype none

module ktr_update (
  input  wire ktr_pkg::entry_t             cur_i,
  input  wire logic                        down_i,
  input  wire logic [ktr_pkg::TimeW-1:0]   now_i,
  input  wire logic [ktr_pkg::CfgW-1:0]    delay_i,
  input  wire logic [ktr_pkg::CfgW-1:0]    interval_i,
  output ktr_pkg::entry_t                  nxt_o,
  output logic                             emit_o
);

  logic [ktr_pkg::TimeW-1:0] elapsed;
  logic [ktr_pkg::CfgW-1:0]  limit;

  assign elapsed = now_i - cur_i.stamp;
  assign limit   = cur_i.rpt ? interval_i : delay_i;

  always_comb begin
    nxt_o  = cur_i;
    emit_o = 1'b0;
    if (!down_i) begin
      nxt_o.held = 1'b0;
    end else if (!cur_i.held) begin
      nxt_o.held  = 1'b1;
      nxt_o.rpt   = 1'b0;
      nxt_o.stamp = now_i;
      emit_o      = 1'b1;
    end else if (elapsed >= {{(ktr_pkg::TimeW-ktr_pkg::CfgW){1'b0}}, limit}) begin
      nxt_o.rpt   = 1'b1;
      nxt_o.stamp = now_i;
      emit_o      = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: sv/keyboard_typematic_repeat_top.sv
// ----------------------------------------------------------------------------
// keyboard_typematic_repeat_top
// Keyboard auto-repeat: per-key held/repeat state and last event time in a
// state memory, read-modify-write per sampled key.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             key_index, key_down, now_ms
//   m_axis    out  tvalid/tready             char_code, key_code
//   cfg       in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the output does not stall; at the transfer the
// state memory is read and the stage register loads; update and write back
// follow, and an emitting key's result is loaded into the output register.
// Back-to-back samples of the same key are served by write-to-read forwarding.
// Reset clears all key state at once through per-entry valid bits; no sweep.
// A full, undrained output register stalls an emitting update stage and the input.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_typematic_repeat_top #(
  parameter int unsigned NUM_KEYS = ktr_pkg::NumKeys
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [47:0]                s_axis_tdata,   // key_index, key_down, now_ms, pad
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // char_code, key_code
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [ktr_pkg::CfgW-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [ktr_pkg::CfgW-1:0]  delay_q, interval_q;
  logic [ktr_pkg::KeyW-1:0]  in_key;
  logic                      in_down;
  logic [ktr_pkg::TimeW-1:0] in_now;
  logic                      in_range;
  logic                      accept;

  logic                      s1_valid_q, s1_valid_d;
  logic [ktr_pkg::KeyW-1:0]  s1_key_q;
  logic                      s1_down_q;
  logic [ktr_pkg::TimeW-1:0] s1_now_q;
  logic                      s1_done;

  ktr_pkg::entry_t           cur_entry, nxt_entry;
  logic                      emit;

  logic                      out_valid_q, out_valid_d;
  logic [15:0]               out_data_q;

  assign in_key   = s_axis_tdata[7:0];
  assign in_down  = s_axis_tdata[8];
  assign in_now   = s_axis_tdata[40:9];
  assign in_range = {1'b0, in_key} < 9'(NUM_KEYS);

  assign s1_done       = s1_valid_q && (!emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= ktr_pkg::DelayRst;
      interval_q <= ktr_pkg::IntervalRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ktr_pkg::RegInitialDelay:   delay_q    <= cfg_wdata_i;
        ktr_pkg::RegRepeatInterval: interval_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ktr_ram #(
    .NUM_KEYS (NUM_KEYS),
    .AW       (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (in_key[AW-1:0]),
    .wr_en_i   (s1_done),
    .wr_addr_i (s1_key_q[AW-1:0]),
    .wr_data_i (nxt_entry),
    .rd_data_o (cur_entry)
  );

  ktr_update u_update (
    .cur_i      (cur_entry),
    .down_i     (s1_down_q),
    .now_i      (s1_now_q),
    .delay_i    (delay_q),
    .interval_i (interval_q),
    .nxt_o      (nxt_entry),
    .emit_o     (emit)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tready) begin
      s1_valid_d = accept && in_range;
    end
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (s1_done && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_key_q  <= in_key;
      s1_down_q <= in_down;
      s1_now_q  <= in_now;
    end
    if (s1_done && emit) begin
      out_data_q <= {s1_key_q, ktr_pkg::scan_char(s1_key_q)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_out_from_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without an update stage item");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_done) |-> (out_valid_q && !m_axis_tready && emit))
    else $error("update stage stalled without a blocked result");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_done) |=> (s1_valid_q && $stable(s1_key_q) && $stable(s1_now_q)))
    else $error("stalled update stage item changed");

endmodule

`default_nettype wire
